// ----- hdl/afc_pkg.sv -----
`timescale 1ns / 1ps

package afc_pkg;

   localparam int COORD_W    = 16;   // Q11.4 corner coordinate
   localparam int C2_W       = 17;   // doubled centre / extent
   localparam int PROD_W     = 34;   // 17 x 17 signed product
   localparam int SUM_W      = 37;   // six products plus headroom
   localparam int PLANE_W    = 64;
   localparam int NUM_PLANES = 6;
   localparam int NUM_AXES   = 3;
   localparam int TAG_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int W_SHIFT    = 15;   // -2w, rescaled by 2^14

   typedef logic signed [C2_W-1:0] coord2_type;

   typedef struct packed {
      coord2_type x;
      coord2_type y;
      coord2_type z;
   } vec2_type;

   // stage enables handed to each plane tester
   typedef struct packed {
      logic mul_en;
      logic sum_en;
   } pipe_en_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NEAR_PLANE     = 3'd0,
      CSR_FAR_PLANE      = 3'd1,
      CSR_LEFT_PLANE     = 3'd2,
      CSR_RIGHT_PLANE    = 3'd3,
      CSR_TOP_PLANE      = 3'd4,
      CSR_BOTTOM_PLANE   = 3'd5,
      CSR_TRANSPARENT_EN = 3'd6
   } csr_index_type;

endpackage

// ----- hdl/afc_prep.sv -----
`timescale 1ns / 1ps

// doubled centre and extent per axis
module afc_prep import afc_pkg::*; (
   input  logic                      clock,
   input  logic                      enable,
   input  logic signed [COORD_W-1:0] box_min_x,
   input  logic signed [COORD_W-1:0] box_min_y,
   input  logic signed [COORD_W-1:0] box_min_z,
   input  logic signed [COORD_W-1:0] box_max_x,
   input  logic signed [COORD_W-1:0] box_max_y,
   input  logic signed [COORD_W-1:0] box_max_z,
   output vec2_type                  c2_ff,
   output vec2_type                  e2_ff
);

   vec2_type c2_in;
   vec2_type e2_in;

   always_comb begin
      c2_in.x = C2_W'(box_min_x) + C2_W'(box_max_x);
      c2_in.y = C2_W'(box_min_y) + C2_W'(box_max_y);
      c2_in.z = C2_W'(box_min_z) + C2_W'(box_max_z);
      // inverted boxes give a negative extent, kept as is
      e2_in.x = C2_W'(box_max_x) - C2_W'(box_min_x);
      e2_in.y = C2_W'(box_max_y) - C2_W'(box_min_y);
      e2_in.z = C2_W'(box_max_z) - C2_W'(box_min_z);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         c2_ff <= c2_in;
         e2_ff <= e2_in;
      end
   end

endmodule

// ----- hdl/afc_plane_test.sv -----
`timescale 1ns / 1ps

// one plane: multiply stage, sum stage, compare on the sum register
module afc_plane_test import afc_pkg::*; (
   input  logic               clock,
   input  pipe_en_type        en,
   input  logic [PLANE_W-1:0] plane,
   input  vec2_type           c2,
   input  vec2_type           e2,
   output logic               behind
);

   logic signed [COORD_W-1:0] n     [NUM_AXES];
   logic signed [COORD_W-1:0] w;
   logic signed [C2_W-1:0]    n_abs [NUM_AXES];
   coord2_type                cv    [NUM_AXES];
   coord2_type                ev    [NUM_AXES];

   logic signed [PROD_W-1:0]  prod_d_in [NUM_AXES];
   logic signed [PROD_W-1:0]  prod_r_in [NUM_AXES];
   logic signed [PROD_W-1:0]  prod_d_ff [NUM_AXES];
   logic signed [PROD_W-1:0]  prod_r_ff [NUM_AXES];
   logic signed [SUM_W-1:0]   rhs_in;
   logic signed [SUM_W-1:0]   rhs_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [SUM_W-1:0]   sum_ff;

   always_comb begin
      n[0] = plane[15:0];
      n[1] = plane[31:16];
      n[2] = plane[47:32];
      w    = plane[63:48];
      cv[0] = c2.x;
      cv[1] = c2.y;
      cv[2] = c2.z;
      ev[0] = e2.x;
      ev[1] = e2.y;
      ev[2] = e2.z;
      for (int i = 0; i < NUM_AXES; i++) begin
         // 17 bits so that |-1.0| stays positive
         n_abs[i] = n[i][COORD_W-1] ? -C2_W'(n[i]) : C2_W'(n[i]);
         prod_d_in[i] = PROD_W'(n[i]) * PROD_W'(cv[i]);
         prod_r_in[i] = PROD_W'(n_abs[i]) * PROD_W'(ev[i]);
      end
      rhs_in = -(SUM_W'(w) <<< W_SHIFT);
      sum_in = SUM_W'(prod_d_ff[0]) + SUM_W'(prod_d_ff[1]) + SUM_W'(prod_d_ff[2])
             + SUM_W'(prod_r_ff[0]) + SUM_W'(prod_r_ff[1]) + SUM_W'(prod_r_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en.mul_en) begin
         prod_d_ff <= prod_d_in;
         prod_r_ff <= prod_r_in;
      end
      if (en.sum_en) begin
         sum_ff <= sum_in;
         rhs_ff <= rhs_in;
      end
   end

   assign behind = (sum_ff <= rhs_ff);

endmodule

// ----- hdl/aabb_frustum_cull_unit.sv -----
`timescale 1ns / 1ps

// AABB frustum cull: one box per transaction is tested against six planes held in
// configuration (d + r <= -2w on any plane culls it) and one result transaction
// comes out for every box, in order. The unit is a four-stage pipeline (doubled
// centre/extent, 36 parallel multipliers, per-plane sum, compare and routing into
// the output register), so a box passes the prep, product and sum registers before
// rsp_valid is set, and throughput is one transaction per clock whenever rsp_ready
// is held high. Each stage only holds when it is full and the one after it is
// blocked, so bubbles close up and req_ready depends combinationally on rsp_ready.
// Plane and transparent_enabled writes are to be made while the pipeline is empty.
// After reset all planes are zero, so every box is culled until software loads them.
module aabb_frustum_cull_unit import afc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // box transactions
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_box_min_x,
   input  logic signed [COORD_W-1:0] req_box_min_y,
   input  logic signed [COORD_W-1:0] req_box_min_z,
   input  logic signed [COORD_W-1:0] req_box_max_x,
   input  logic signed [COORD_W-1:0] req_box_max_y,
   input  logic signed [COORD_W-1:0] req_box_max_z,
   input  logic                      req_is_blended,
   input  logic [TAG_W-1:0]          req_item_tag,
   input  logic                      req_last_item,
   // result transactions
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [TAG_W-1:0]          rsp_tag_out,
   output logic                      rsp_accepted,
   output logic                      rsp_list_select,
   output logic                      rsp_last_out,
   // configuration writes
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [PLANE_W-1:0]        csr_wdata
);

   // fields that ride alongside the arithmetic
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             blended;
      logic             last;
   } side_type;

   // configuration registers
   logic [PLANE_W-1:0] plane_ff [NUM_PLANES];
   logic               transparent_ff;

   // stage valids
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic en1, en2, en3, en4;

   side_type side1_ff, side2_ff, side3_ff;
   side_type side_req;

   vec2_type    c2, e2;
   pipe_en_type plane_en;
   logic [NUM_PLANES-1:0] behind;

   logic             culled;
   logic             accepted_in;
   logic             list_in;
   logic [TAG_W-1:0] tag_ff;
   logic             accepted_ff, list_ff, last_ff;

   //----------------------------------------------------------------------------
   // configuration: unused index is ignored
   //----------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
         transparent_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NEAR_PLANE:     plane_ff[0]    <= csr_wdata;
            CSR_FAR_PLANE:      plane_ff[1]    <= csr_wdata;
            CSR_LEFT_PLANE:     plane_ff[2]    <= csr_wdata;
            CSR_RIGHT_PLANE:    plane_ff[3]    <= csr_wdata;
            CSR_TOP_PLANE:      plane_ff[4]    <= csr_wdata;
            CSR_BOTTOM_PLANE:   plane_ff[5]    <= csr_wdata;
            CSR_TRANSPARENT_EN: transparent_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   //----------------------------------------------------------------------------
   // pipeline control: a stage moves when empty or when its successor moves
   //----------------------------------------------------------------------------
   assign en4 = !rsp_valid_ff || rsp_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) v1_ff        <= req_valid;
         if (en2) v2_ff        <= v1_ff;
         if (en3) v3_ff        <= v2_ff;
         if (en4) rsp_valid_ff <= v3_ff;
      end
   end

   assign side_req = '{tag: req_item_tag, blended: req_is_blended, last: req_last_item};

   always_ff @(posedge clock) begin
      if (en1) side1_ff <= side_req;
      if (en2) side2_ff <= side1_ff;
      if (en3) side3_ff <= side2_ff;
   end

   //----------------------------------------------------------------------------
   // stage 1: doubled centre and extent
   //----------------------------------------------------------------------------
   afc_prep u_prep (
      .clock     (clock),
      .enable    (en1),
      .box_min_x (req_box_min_x),
      .box_min_y (req_box_min_y),
      .box_min_z (req_box_min_z),
      .box_max_x (req_box_max_x),
      .box_max_y (req_box_max_y),
      .box_max_z (req_box_max_z),
      .c2_ff     (c2),
      .e2_ff     (e2)
   );

   //----------------------------------------------------------------------------
   // stages 2 and 3: one tester per plane
   //----------------------------------------------------------------------------
   assign plane_en = '{mul_en: en2, sum_en: en3};

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      afc_plane_test u_test (
         .clock  (clock),
         .en     (plane_en),
         .plane  (plane_ff[p]),
         .c2     (c2),
         .e2     (e2),
         .behind (behind[p])
      );
   end

   //----------------------------------------------------------------------------
   // stage 4: cull decision and list routing into the output register
   //----------------------------------------------------------------------------
   assign culled      = |behind;
   assign accepted_in = !culled && (!side3_ff.blended || transparent_ff);
   assign list_in     = accepted_in && side3_ff.blended;

   always_ff @(posedge clock) begin
      if (en4) begin
         tag_ff      <= side3_ff.tag;
         accepted_ff <= accepted_in;
         list_ff     <= list_in;
         last_ff     <= side3_ff.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tag_out     = tag_ff;
   assign rsp_accepted    = accepted_ff;
   assign rsp_list_select = list_ff;
   assign rsp_last_out    = last_ff;

endmodule

// ----- hdl/afc_checker.sv -----
`timescale 1ns / 1ps

module afc_checker import afc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [TAG_W-1:0] rsp_tag_out,
   input logic             rsp_accepted,
   input logic             rsp_list_select,
   input logic             rsp_last_out
);

   // transactions in flight: pipeline holds at most four
   logic [2:0] occ_ff;
   logic [2:0] occ_in;
   logic       take_in, take_out;

   assign take_in  = req_valid && req_ready;
   assign take_out = rsp_valid && rsp_ready;

   always_comb begin
      occ_in = occ_ff;
      if (take_in && !take_out) occ_in = occ_ff + 3'd1;
      if (!take_in && take_out) occ_in = occ_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tag_out)
         && $stable(rsp_accepted) && $stable(rsp_list_select) && $stable(rsp_last_out))
      else $error("result changed while stalled");

   a_list_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_select |-> rsp_accepted)
      else $error("transparent route on a rejected box");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occ_ff != 3'd0)
      else $error("result without a pending request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= 3'd4)
      else $error("more transactions in flight than pipeline stages");

endmodule

bind aabb_frustum_cull_unit afc_checker u_afc_checker (.*);
